// ===== rtl/kqt_pkg.sv =====
// Shared types and constants for the keyframe quintic trajectory player.
package kqt_pkg;

    localparam int FUNC_W    = 2;
    localparam int KF_IDX_W  = 2;
    localparam int JOINT_W   = 5;
    localparam int VALUE_W   = 32;
    localparam int TICKS_W   = 16;
    localparam int TICK_W    = 18;
    localparam int END_W     = 20;

    localparam int DEF_NUM_JOINTS    = 32;
    localparam int DEF_NUM_KEYFRAMES = 4;

    localparam logic [TICKS_W-1:0] SEG_TICKS_RESET = 16'd800;
    localparam logic [TICK_W-1:0]  TICK_MAX        = '1;
    localparam logic [VALUE_W-1:0] ONE_Q30         = 32'h4000_0000;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_RESTART = 2'd1,
        FUNC_TICK    = 2'd2
    } func_t;

endpackage

// ===== rtl/keyframe_quintic_trajectory.sv =====
// Keyframe quintic trajectory player: sequencer, keyframe store and shared datapath.
//
// After reset the keyframe store (NUM_KEYFRAMES*NUM_JOINTS words) is zeroed by a
// clearing pass over every word; item_stall stays high during it,
// while segment_ticks writes are taken at any time. Load and restart items leave
// the block idle. A tick item runs on one shared 34x17 multiplier and one shared
// 19-bit subtractor: a search for the segment, a 30-bit restoring division for s,
// the powers of s up to the fifth, then per joint two store reads, four partial
// products, a 35-step restoring divide of the velocity by segment_ticks and one
// output load. Once the timer has reached the end of the motion a tick only reads
// each joint's last keyframe and emits it with zero velocity. The block accepts the
// next item while the final result of a tick still sits in the output register.
module keyframe_quintic_trajectory #(
    parameter int NUM_JOINTS    = kqt_pkg::DEF_NUM_JOINTS,
    parameter int NUM_KEYFRAMES = kqt_pkg::DEF_NUM_KEYFRAMES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [kqt_pkg::TICKS_W-1:0]         cfg_write_data,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [kqt_pkg::FUNC_W-1:0]          func,
    input  logic [kqt_pkg::KF_IDX_W-1:0]        keyframe_index,
    input  logic [kqt_pkg::JOINT_W-1:0]         joint_select,
    input  logic signed [kqt_pkg::VALUE_W-1:0]  keyframe_value,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [kqt_pkg::JOINT_W-1:0]         joint_index,
    output logic signed [kqt_pkg::VALUE_W-1:0]  position,
    output logic signed [kqt_pkg::VALUE_W-1:0]  velocity,
    output logic                                last
);
    import kqt_pkg::*;

    localparam int DEPTH    = NUM_KEYFRAMES * NUM_JOINTS;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int KF_W     = $clog2(NUM_KEYFRAMES);
    localparam int JNT_W    = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int KF_LAST  = NUM_KEYFRAMES - 1;
    localparam int JNT_LAST = NUM_JOINTS - 1;

    localparam int Q_FRAC  = 30;
    localparam int S_W     = 30;
    localparam int CHUNK_W = 16;
    localparam int MULA_W  = 34;
    localparam int MULP_W  = MULA_W + CHUNK_W + 1;
    localparam int ACC_W   = 66;
    localparam int V_W     = ACC_W - Q_FRAC;
    localparam int NUM_W   = 35;
    localparam int SUM_W   = 40;
    localparam int DIFF_W  = VALUE_W + 1;
    localparam int SUB_W   = TICK_W + 1;
    localparam int CNT_W   = 6;
    localparam int STEP_W  = 3;

    localparam logic [CNT_W-1:0] PW_SQ    = CNT_W'(2);
    localparam logic [CNT_W-1:0] PW_CUBE  = CNT_W'(3);
    localparam logic [CNT_W-1:0] PW_QUART = CNT_W'(4);
    localparam logic [CNT_W-1:0] PW_QUINT = CNT_W'(5);

    localparam logic [VALUE_W-1:0] VEL_MAX     = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VEL_MIN     = 32'h8000_0000;
    localparam logic [NUM_W-1:0]   VEL_MAX_MAG = NUM_W'(VEL_MAX);
    localparam logic [NUM_W-1:0]   VEL_MIN_MAG = NUM_W'(VEL_MIN);

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_SEG  = 10'b00_0000_0010,
        ST_SDIV = 10'b00_0000_0100,
        ST_POW  = 10'b00_0000_1000,
        ST_RD0  = 10'b00_0001_0000,
        ST_RD1  = 10'b00_0010_0000,
        ST_DIFF = 10'b00_0100_0000,
        ST_MUL  = 10'b00_1000_0000,
        ST_DIV  = 10'b01_0000_0000,
        ST_EMIT = 10'b10_0000_0000
    } state_t;

    // control
    state_t                     state_reg, state_next;
    logic [TICKS_W-1:0]         seg_ticks_reg, seg_ticks_next;
    logic [TICK_W-1:0]          tick_reg, tick_next;
    logic                       clr_reg, clr_next;
    logic [ADDR_W-1:0]          clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic [JNT_W-1:0]           jnt_reg, jnt_next;
    logic                       result_valid_reg, result_valid_next;

    // datapath
    logic                       hold_reg, hold_next;
    logic [KF_W-1:0]            seg_reg, seg_next;
    logic [TICK_W-1:0]          rem_reg, rem_next;
    logic [S_W-1:0]             s_reg, s_next;
    logic [S_W-1:0]             pw_reg, pw_next;
    logic signed [SUM_W-1:0]    bacc_reg, bacc_next;
    logic signed [SUM_W-1:0]    racc_reg, racc_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [VALUE_W-1:0]  p0_reg, p0_next;
    logic signed [DIFF_W-1:0]   diff_reg, diff_next;
    logic signed [VALUE_W-1:0]  pos_reg, pos_next;
    logic [NUM_W-1:0]           num_reg, num_next;
    logic                       neg_reg, neg_next;
    logic [JOINT_W-1:0]         joint_index_reg, joint_index_next;
    logic signed [VALUE_W-1:0]  position_reg, position_next;
    logic signed [VALUE_W-1:0]  velocity_reg, velocity_next;
    logic                       last_reg, last_next;

    // keyframe store
    logic [VALUE_W-1:0]         mem [DEPTH];
    logic signed [VALUE_W-1:0]  rd_data_reg;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [VALUE_W-1:0]         mem_wdata;
    logic [ADDR_W-1:0]          mem_raddr;
    logic [ADDR_W-1:0]          addr0;
    logic [ADDR_W-1:0]          addr1;
    logic [ADDR_W-1:0]          load_addr;
    logic                       load_ok;

    logic                       item_accept;
    logic [TICKS_W-1:0]         t_eff;
    logic [END_W-1:0]           seg_end;

    // shared subtractor
    logic [TICK_W-1:0]          sub_a;
    logic [SUB_W-1:0]           sub_diff;
    logic                       sub_ge;

    // shared multiplier
    logic signed [MULA_W-1:0]   mul_a;
    logic [CHUNK_W-1:0]         mul_chunk;
    logic signed [MULP_W-1:0]   mul_prod;
    logic signed [ACC_W-1:0]    acc_lo;
    logic signed [ACC_W-1:0]    acc_hi;

    logic [VALUE_W-1:0]         blend_q;
    logic [VALUE_W-1:0]         rate_q;
    logic [S_W-1:0]             pw_new;
    logic signed [SUM_W-1:0]    pw_ext;
    logic signed [SUM_W-1:0]    x6;
    logic signed [SUM_W-1:0]    x10;
    logic signed [SUM_W-1:0]    x15;
    logic signed [SUM_W-1:0]    x30;
    logic signed [SUM_W-1:0]    x60;
    logic signed [V_W-1:0]      v_floor;
    logic [V_W-1:0]             v_mag;
    logic [NUM_W-1:0]           num_neg;
    logic [VALUE_W-1:0]         vel_sat;
    logic [S_W-1:0]             s_shift;

    assign item_stall   = (state_reg != ST_IDLE) || clr_reg;
    assign item_accept  = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign joint_index  = joint_index_reg;
    assign position     = position_reg;
    assign velocity     = velocity_reg;
    assign last         = last_reg;

    assign t_eff   = (seg_ticks_reg == '0) ? TICKS_W'(1) : seg_ticks_reg;
    assign seg_end = END_W'(KF_LAST) * {{(END_W-TICKS_W){1'b0}}, t_eff};

    assign addr0     = ADDR_W'(int'(seg_reg) * NUM_JOINTS + int'(jnt_reg));
    assign addr1     = ADDR_W'((int'(seg_reg) + 1) * NUM_JOINTS + int'(jnt_reg));
    assign load_addr = ADDR_W'(int'(keyframe_index) * NUM_JOINTS + int'(joint_select));
    assign load_ok   = (int'(keyframe_index) < NUM_KEYFRAMES)
                    && (int'(joint_select) < NUM_JOINTS);

    assign mem_we    = clr_reg || (item_accept && func == FUNC_LOAD && load_ok);
    assign mem_waddr = clr_reg ? clr_addr_reg : load_addr;
    assign mem_wdata = clr_reg ? '0 : keyframe_value;
    assign mem_raddr = (state_reg == ST_RD1) ? addr1 : addr0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // shared subtractor: segment search, s division, velocity division
    always_comb
    begin
        case (state_reg)
            ST_SDIV: sub_a = {1'b0, rem_reg[TICKS_W-1:0], 1'b0};
            ST_DIV:  sub_a = {1'b0, rem_reg[TICKS_W-1:0], num_reg[NUM_W-1]};
            default: sub_a = rem_reg;
        endcase
    end

    assign sub_diff = {1'b0, sub_a} - {{(SUB_W-TICKS_W){1'b0}}, t_eff};
    assign sub_ge   = ~sub_diff[SUB_W-1];
    assign s_shift  = {s_reg[S_W-2:0], sub_ge};

    // blend and rate, clamped
    always_comb
    begin
        if (bacc_reg < 0)
        begin
            blend_q = '0;
        end
        else if (bacc_reg > $signed({{(SUM_W-VALUE_W){1'b0}}, ONE_Q30}))
        begin
            blend_q = ONE_Q30;
        end
        else
        begin
            blend_q = bacc_reg[VALUE_W-1:0];
        end
        rate_q = racc_reg[SUM_W-1] ? '0 : racc_reg[VALUE_W-1:0];
    end

    // shared multiplier, one 16-bit chunk of the second operand per cycle
    always_comb
    begin
        mul_a     = $signed({{(MULA_W-S_W){1'b0}}, pw_reg});
        mul_chunk = '0;
        case (state_reg)
            ST_POW:
            begin
                mul_a = $signed({{(MULA_W-S_W){1'b0}}, pw_reg});
                if (step_reg == STEP_W'(0))
                begin
                    mul_chunk = s_reg[CHUNK_W-1:0];
                end
                else
                begin
                    mul_chunk = {{(2*CHUNK_W-S_W){1'b0}}, s_reg[S_W-1:CHUNK_W]};
                end
            end
            ST_MUL:
            begin
                mul_a = MULA_W'(diff_reg);
                case (step_reg)
                    STEP_W'(0): mul_chunk = blend_q[CHUNK_W-1:0];
                    STEP_W'(1): mul_chunk = blend_q[VALUE_W-1:CHUNK_W];
                    STEP_W'(2): mul_chunk = rate_q[CHUNK_W-1:0];
                    STEP_W'(3): mul_chunk = rate_q[VALUE_W-1:CHUNK_W];
                    default:    mul_chunk = '0;
                endcase
            end
            default:
            begin
                mul_chunk = '0;
            end
        endcase
    end

    assign mul_prod = mul_a * $signed({1'b0, mul_chunk});
    assign acc_lo   = ACC_W'(mul_prod);
    assign acc_hi   = acc_reg + (ACC_W'(mul_prod) <<< CHUNK_W);

    assign pw_new = acc_reg[Q_FRAC +: S_W];
    assign pw_ext = $signed({{(SUM_W-S_W){1'b0}}, pw_new});
    assign x6     = (pw_ext <<< 2) + (pw_ext <<< 1);
    assign x10    = (pw_ext <<< 3) + (pw_ext <<< 1);
    assign x15    = (pw_ext <<< 4) - pw_ext;
    assign x30    = (pw_ext <<< 5) - (pw_ext <<< 1);
    assign x60    = (pw_ext <<< 6) - (pw_ext <<< 2);

    assign v_floor = acc_reg[ACC_W-1:Q_FRAC];
    assign v_mag   = v_floor[V_W-1] ? (V_W'(0) - v_floor) : v_floor;
    assign num_neg = NUM_W'(0) - num_reg;

    // truncated quotient back to signed, saturated
    always_comb
    begin
        if (hold_reg)
        begin
            vel_sat = '0;
        end
        else if (!neg_reg)
        begin
            vel_sat = (num_reg > VEL_MAX_MAG) ? VEL_MAX : num_reg[VALUE_W-1:0];
        end
        else
        begin
            vel_sat = (num_reg > VEL_MIN_MAG) ? VEL_MIN : num_neg[VALUE_W-1:0];
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        seg_ticks_next    = cfg_write_en ? cfg_write_data : seg_ticks_reg;
        tick_next         = tick_reg;
        clr_next          = clr_reg;
        clr_addr_next     = clr_addr_reg;
        cnt_next          = cnt_reg;
        step_next         = step_reg;
        jnt_next          = jnt_reg;
        result_valid_next = result_valid_reg;
        hold_next         = hold_reg;
        seg_next          = seg_reg;
        rem_next          = rem_reg;
        s_next            = s_reg;
        pw_next           = pw_reg;
        bacc_next         = bacc_reg;
        racc_next         = racc_reg;
        acc_next          = acc_reg;
        p0_next           = p0_reg;
        diff_next         = diff_reg;
        pos_next          = pos_reg;
        num_next          = num_reg;
        neg_next          = neg_reg;
        joint_index_next  = joint_index_reg;
        position_next     = position_reg;
        velocity_next     = velocity_reg;
        last_next         = last_reg;

        if (clr_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clr_next = 1'b0;
            end
        end

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    case (func)
                        FUNC_RESTART:
                        begin
                            tick_next = '0;
                        end
                        FUNC_TICK:
                        begin
                            if (({{(END_W-TICK_W){1'b0}}, tick_reg} < seg_end)
                                && (tick_reg != TICK_MAX))
                            begin
                                tick_next = tick_reg + 1'b1;
                            end
                            jnt_next = '0;
                            if ({{(END_W-TICK_W){1'b0}}, tick_reg} >= seg_end)
                            begin
                                hold_next  = 1'b1;
                                seg_next   = KF_W'(KF_LAST);
                                state_next = ST_RD0;
                            end
                            else
                            begin
                                hold_next  = 1'b0;
                                seg_next   = '0;
                                rem_next   = tick_reg;
                                state_next = ST_SEG;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SEG:
            begin
                if (sub_ge)
                begin
                    rem_next = sub_diff[TICK_W-1:0];
                    seg_next = seg_reg + 1'b1;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = ST_SDIV;
                end
            end
            ST_SDIV:
            begin
                rem_next = sub_ge ? sub_diff[TICK_W-1:0] : sub_a;
                s_next   = s_shift;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(S_W - 1))
                begin
                    pw_next    = s_shift;
                    bacc_next  = '0;
                    racc_next  = '0;
                    cnt_next   = PW_SQ;
                    step_next  = '0;
                    state_next = ST_POW;
                end
            end
            ST_POW:
            begin
                case (step_reg)
                    STEP_W'(0):
                    begin
                        acc_next  = acc_lo;
                        step_next = STEP_W'(1);
                    end
                    STEP_W'(1):
                    begin
                        acc_next  = acc_hi;
                        step_next = STEP_W'(2);
                    end
                    default:
                    begin
                        pw_next   = pw_new;
                        step_next = '0;
                        case (cnt_reg)
                            PW_SQ:
                            begin
                                racc_next = racc_reg + x30;
                            end
                            PW_CUBE:
                            begin
                                bacc_next = bacc_reg + x10;
                                racc_next = racc_reg - x60;
                            end
                            PW_QUART:
                            begin
                                bacc_next = bacc_reg - x15;
                                racc_next = racc_reg + x30;
                            end
                            default:
                            begin
                                bacc_next = bacc_reg + x6;
                            end
                        endcase
                        if (cnt_reg == PW_QUINT)
                        begin
                            state_next = ST_RD0;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                endcase
            end
            ST_RD0:
            begin
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                p0_next = rd_data_reg;
                if (hold_reg)
                begin
                    pos_next   = rd_data_reg;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                diff_next  = DIFF_W'(rd_data_reg) - DIFF_W'(p0_reg);
                step_next  = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    STEP_W'(0):
                    begin
                        acc_next = acc_lo;
                    end
                    STEP_W'(1):
                    begin
                        acc_next = acc_hi;
                    end
                    STEP_W'(2):
                    begin
                        pos_next = p0_reg + $signed(acc_reg[Q_FRAC +: VALUE_W]);
                        acc_next = acc_lo;
                    end
                    STEP_W'(3):
                    begin
                        acc_next = acc_hi;
                    end
                    default:
                    begin
                        neg_next   = v_floor[V_W-1];
                        num_next   = v_mag[NUM_W-1:0];
                        rem_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_DIV;
                    end
                endcase
            end
            ST_DIV:
            begin
                rem_next = sub_ge ? sub_diff[TICK_W-1:0] : sub_a;
                num_next = {num_reg[NUM_W-2:0], sub_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    joint_index_next  = JOINT_W'(jnt_reg);
                    position_next     = pos_reg;
                    velocity_next     = vel_sat;
                    last_next         = (jnt_reg == JNT_W'(JNT_LAST));
                    if (jnt_reg == JNT_W'(JNT_LAST))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        jnt_next   = jnt_reg + 1'b1;
                        state_next = ST_RD0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            seg_ticks_reg    <= SEG_TICKS_RESET;
            tick_reg         <= '0;
            clr_reg          <= 1'b1;
            clr_addr_reg     <= '0;
            cnt_reg          <= '0;
            step_reg         <= '0;
            jnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            seg_ticks_reg    <= seg_ticks_next;
            tick_reg         <= tick_next;
            clr_reg          <= clr_next;
            clr_addr_reg     <= clr_addr_next;
            cnt_reg          <= cnt_next;
            step_reg         <= step_next;
            jnt_reg          <= jnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg        <= hold_next;
        seg_reg         <= seg_next;
        rem_reg         <= rem_next;
        s_reg           <= s_next;
        pw_reg          <= pw_next;
        bacc_reg        <= bacc_next;
        racc_reg        <= racc_next;
        acc_reg         <= acc_next;
        p0_reg          <= p0_next;
        diff_reg        <= diff_next;
        pos_reg         <= pos_next;
        num_reg         <= num_next;
        neg_reg         <= neg_next;
        joint_index_reg <= joint_index_next;
        position_reg    <= position_next;
        velocity_reg    <= velocity_next;
        last_reg        <= last_next;
    end

endmodule

// ===== rtl/kqt_checker.sv =====
// Port-level assertions for the keyframe quintic trajectory player, with bind.
module kqt_checker #(
    parameter int NUM_JOINTS = kqt_pkg::DEF_NUM_JOINTS
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                item_valid,
    input logic                                item_stall,
    input logic [kqt_pkg::FUNC_W-1:0]          func,
    input logic                                result_valid,
    input logic                                result_stall,
    input logic [kqt_pkg::JOINT_W-1:0]         joint_index,
    input logic signed [kqt_pkg::VALUE_W-1:0]  position,
    input logic signed [kqt_pkg::VALUE_W-1:0]  velocity,
    input logic                                last
);
    import kqt_pkg::*;

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(joint_index)
            && $stable(position) && $stable(velocity) && $stable(last))
        else $error("result changed while stalled");

    // a tick occupies the block
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && func == FUNC_TICK |=> item_stall)
        else $error("item taken right after a tick transfer");

    // mid-run results only while the tick is still in progress
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !last |-> item_stall)
        else $error("non-final result transfer while block idle");

    a_last_joint: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |-> joint_index == JOINT_W'(NUM_JOINTS - 1))
        else $error("last flag on wrong joint");

endmodule

bind keyframe_quintic_trajectory kqt_checker #(
    .NUM_JOINTS(NUM_JOINTS)
) u_kqt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .func         (func),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .joint_index  (joint_index),
    .position     (position),
    .velocity     (velocity),
    .last         (last)
);
